// ===== src/clipped_colorkey_blit_writer_assert.svh =====
// assertion macros for the blit writer
`ifndef CLIPPED_COLORKEY_BLIT_WRITER_ASSERT_SVH
`define CLIPPED_COLORKEY_BLIT_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CCKB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CCKB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CCKB_ASSERT(lbl, prop, msg)
`define CCKB_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== src/cckb_pkg.sv =====
package cckb_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam logic [11:0] COL_MAX = 12'd4095;
    localparam logic [12:0] ROW_MAX = 13'd8191;

    localparam logic [31:0] MASK_555_B = 32'h0000_001F;
    localparam logic [31:0] MASK_555_G = 32'h0000_03E0;
    localparam logic [31:0] MASK_555_R = 32'h0000_7C00;
    localparam logic [31:0] MASK_565_G = 32'h0000_07E0;
    localparam logic [31:0] MASK_565_R = 32'h0000_F800;
    localparam logic [31:0] MASK_RGB24 = 32'h00FF_FFFF;

    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd1;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_PIXEL_FORMAT  = 3'd2,
        REG_DEST_X        = 3'd3,
        REG_DEST_Y        = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_COLOR_KEY     = 3'd6,
        REG_KEY_ENABLE    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_RGB32  = 2'd3
    } pixel_format_t;

    localparam logic [2:0] BYTES_16 = 3'd2;
    localparam logic [2:0] BYTES_24 = 3'd3;
    localparam logic [2:0] BYTES_32 = 3'd4;

    typedef struct packed {
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        pixel_format_t      pixel_format;
        logic signed [12:0] dest_x;
        logic signed [12:0] dest_y;
        logic [12:0]        image_width;
        logic [31:0]        color_key;
        logic               key_enable;
    } cfg_t;

    typedef struct packed {
        logic        keep;
        logic [25:0] fb_offset;
        logic [31:0] write_data;
        logic [2:0]  byte_count;
    } result_t;

    function automatic logic [31:0] to_rgb555(input logic [31:0] c);
        return ((c >> 3) & MASK_555_B) | ((c >> 6) & MASK_555_G) | ((c >> 9) & MASK_555_R);
    endfunction

    function automatic logic [31:0] to_rgb565(input logic [31:0] c);
        return ((c >> 3) & MASK_555_B) | ((c >> 5) & MASK_565_G) | ((c >> 8) & MASK_565_R);
    endfunction

endpackage

// ===== src/clipped_colorkey_blit_writer.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata source_pixel, tlast last_pixel
// m_        out  m_tvalid/m_tready  tdata fb_offset, write_data, byte_count
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// one pixel per cycle sustained while m_tready is high; an input transaction passes to the result
// through the input register, then clip/convert/offset multiply into the output register
// reset is synchronous, active low; config back to defaults, counters to zero
// a stalled result holds in the output register while one more pixel is taken
// s_tready drops only when both registers are full and m_tready is low
`include "clipped_colorkey_blit_writer_assert.svh"

module clipped_colorkey_blit_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // source_pixel
    input  logic        s_tlast,   // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // fb_offset[25:0], write_data[57:26], byte_count[60:58]
);

    cckb_pkg::cfg_t    cfg;
    cckb_pkg::result_t result;

    logic [11:0] column;
    logic [12:0] row;
    logic        s_accept;
    logic        out_free;

    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_pixel_reg;
    logic [11:0] s1_column_reg;
    logic [12:0] s1_row_reg;

    logic        out_valid_reg, out_valid_next;
    logic [25:0] out_offset_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_bytes_reg;

    cckb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cckb_pos_counter u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_accept),
        .last        (s_tlast),
        .image_width (cfg.image_width),
        .column      (column),
        .row         (row)
    );

    cckb_pixel_eval u_eval (
        .cfg    (cfg),
        .pixel  (s1_pixel_reg),
        .column (s1_column_reg),
        .row    (s1_row_reg),
        .result (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg && result.keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg  <= s_tdata;
            s1_column_reg <= column;
            s1_row_reg    <= row;
        end
        if (out_free) begin
            out_offset_reg <= result.fb_offset;
            out_data_reg   <= result.write_data;
            out_bytes_reg  <= result.byte_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bytes_reg, out_data_reg, out_offset_reg};

    // checks
    `CCKB_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")
    `CCKB_ASSERT(a_last_clears_pos, s_accept && s_tlast |=> column == 12'd0 && row == 13'd0, "position not cleared after last transaction")
    `CCKB_ASSERT(a_ready_only_when_full, !s_tready |-> s1_valid_reg && m_tvalid && !m_tready, "input stalled without a full pipeline")
    `CCKB_ASSERT(a_narrow_data_zero, m_tvalid && out_bytes_reg == cckb_pkg::BYTES_16 |-> out_data_reg[31:16] == 16'd0, "16-bit result with high bits set")

endmodule

// ===== src/cckb_cfg_regs.sv =====
module cckb_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    output cckb_pkg::cfg_t     cfg
);

    cckb_pkg::cfg_t cfg_reg;
    cckb_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cckb_pkg::reg_index_t'(cfg_index))
                cckb_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[12:0];
                cckb_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[12:0];
                cckb_pkg::REG_PIXEL_FORMAT:
                    cfg_next.pixel_format = cckb_pkg::pixel_format_t'(cfg_wdata[1:0]);
                cckb_pkg::REG_DEST_X:        cfg_next.dest_x        = $signed(cfg_wdata[12:0]);
                cckb_pkg::REG_DEST_Y:        cfg_next.dest_y        = $signed(cfg_wdata[12:0]);
                cckb_pkg::REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_wdata[12:0];
                cckb_pkg::REG_COLOR_KEY:     cfg_next.color_key     = cfg_wdata;
                cckb_pkg::REG_KEY_ENABLE:    cfg_next.key_enable    = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= cckb_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= cckb_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.pixel_format  <= cckb_pkg::FMT_RGB32;
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.image_width   <= cckb_pkg::RST_IMAGE_WIDTH;
            cfg_reg.color_key     <= '0;
            cfg_reg.key_enable    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cckb_pos_counter.sv =====
module cckb_pos_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        last,
    input  logic [12:0] image_width,
    output logic [11:0] column,
    output logic [12:0] row
);

    localparam logic [13:0] MAX_W = 14'(cckb_pkg::MAX_DIM);

    logic [11:0] column_reg, column_next;
    logic [12:0] row_reg, row_next;
    logic [13:0] width_eff;
    logic [13:0] column_inc;

    always_comb begin
        width_eff = {1'b0, image_width};
        if (image_width == 13'd0) begin
            width_eff = 14'd1;
        end else if ({1'b0, image_width} > MAX_W) begin
            width_eff = MAX_W;
        end
        column_inc  = {2'b00, column_reg} + 14'd1;
        column_next = column_reg;
        row_next    = row_reg;
        if (step) begin
            if (last) begin
                column_next = '0;
                row_next    = '0;
            end else if (column_inc >= width_eff || column_reg >= cckb_pkg::COL_MAX) begin
                column_next = '0;
                if (row_reg < cckb_pkg::ROW_MAX) begin
                    row_next = row_reg + 13'd1;
                end
            end else begin
                column_next = column_inc[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column = column_reg;
    assign row    = row_reg;

endmodule

// ===== src/cckb_pixel_eval.sv =====
module cckb_pixel_eval (
    input  cckb_pkg::cfg_t    cfg,
    input  logic [31:0]       pixel,
    input  logic [11:0]       column,
    input  logic [12:0]       row,
    output cckb_pkg::result_t result
);

    logic signed [13:0] sx;
    logic signed [14:0] sy;
    logic               visible;
    logic               keyed;
    logic [25:0]        row_base;
    logic [25:0]        idx;

    always_comb begin
        sx = {cfg.dest_x[12], cfg.dest_x} + $signed({2'b00, column});
        sy = {{2{cfg.dest_y[12]}}, cfg.dest_y} + $signed({2'b00, row});
        visible = !sx[13] && !sy[14] &&
                  (sx[12:0] < cfg.screen_width) &&
                  (sy[13:0] < {1'b0, cfg.screen_height});
        keyed = cfg.key_enable && (pixel == cfg.color_key);

        row_base = sy[12:0] * cfg.screen_width;
        idx      = row_base + {13'd0, sx[12:0]};

        result.keep = visible && !keyed;
        case (cfg.pixel_format)
            cckb_pkg::FMT_RGB555: begin
                result.byte_count = cckb_pkg::BYTES_16;
                result.write_data = cckb_pkg::to_rgb555(pixel);
                result.fb_offset  = {idx[24:0], 1'b0};
            end
            cckb_pkg::FMT_RGB565: begin
                result.byte_count = cckb_pkg::BYTES_16;
                result.write_data = cckb_pkg::to_rgb565(pixel);
                result.fb_offset  = {idx[24:0], 1'b0};
            end
            cckb_pkg::FMT_RGB24: begin
                result.byte_count = cckb_pkg::BYTES_24;
                result.write_data = pixel & cckb_pkg::MASK_RGB24;
                result.fb_offset  = {idx[24:0], 1'b0} + idx;
            end
            default: begin
                result.byte_count = cckb_pkg::BYTES_32;
                result.write_data = pixel;
                result.fb_offset  = {idx[23:0], 2'b00};
            end
        endcase
    end

endmodule
